/* design/bpd_pkg.sv */
// Shared types, constants and arithmetic helpers of the Bezier patch vertex deformer.
// Used by every module of the design; depends on nothing.
`timescale 1ns / 1ps

package bpd_pkg;

    localparam int CW   = 32;          // coordinate width
    localparam int FB   = 16;          // fraction bits
    localparam int QW   = FB + 1;      // parameter and weight width, [0, 1.0]
    localparam int NP   = 16;          // control points
    localparam int PIW  = 4;           // point index width
    localparam int DPW  = CW + 1;      // coordinate minus center
    localparam int UPW  = 2 * DPW;     // difference times gain
    localparam int PPW  = CW + QW + 1; // displacement times weight
    localparam int GSW  = PPW + 2;     // sum of four products
    localparam int SUMW = PPW + 4;     // sum of sixteen products
    localparam int DW   = CW + 2;      // patch displacement
    localparam int GPW  = DW + DPW;    // displacement times output gain
    localparam int RW   = GPW - FB + 1;

    localparam logic [QW-1:0]         ONE_Q  = QW'(1) << FB;
    localparam logic [2*QW-1:0]       HALF_P = (2*QW)'(1) << (FB - 1);
    localparam logic signed [UPW-1:0] HALF_U = UPW'(1) << (FB - 1);
    localparam logic signed [UPW-1:0] ONE_U  = UPW'(1) << FB;
    localparam logic [CW-1:0]         GAIN_ONE = CW'(1) << FB;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_VERTEX = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Z   = 3'd1,
        CFG_U_GAIN     = 3'd2,
        CFG_V_GAIN     = 3'd3,
        CFG_OUT_GAIN_X = 3'd4,
        CFG_OUT_GAIN_Y = 3'd5,
        CFG_OUT_GAIN_Z = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_op                    opcode;
        logic [PIW-1:0]         point_index;
        logic signed [CW-1:0]   coord_x;
        logic signed [CW-1:0]   coord_y;
        logic signed [CW-1:0]   coord_z;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0]   out_x;
        logic signed [CW-1:0]   out_y;
        logic signed [CW-1:0]   out_z;
    } t_out;

    typedef struct packed {
        logic vld;
        logic vtx;
    } t_ctl;

    typedef struct packed {
        logic signed [CW-1:0]   center_x;
        logic signed [CW-1:0]   center_z;
        logic [CW-1:0]          u_gain;
        logic [CW-1:0]          v_gain;
        logic [CW-1:0]          out_gain_x;
        logic [CW-1:0]          out_gain_y;
        logic [CW-1:0]          out_gain_z;
    } t_cfg;

    typedef struct packed {
        logic signed [DW-1:0]   d_x;
        logic signed [DW-1:0]   d_y;
        logic signed [DW-1:0]   d_z;
    } t_disp;

    typedef logic [QW-1:0] t_q;
    typedef t_q [3:0]      t_bern;

    function automatic t_q rnd_q(input t_q a, input t_q b);
        logic [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b) + HALF_P;
        return p[FB+QW-1:FB];
    endfunction

    // Floor shift of the gain product, plus one half, clamped to [0, 1].
    function automatic t_q param_clamp(input logic signed [UPW-1:0] p);
        logic signed [UPW-1:0] t;
        t = (p >>> FB) + HALF_U;
        if (t[UPW-1]) begin
            return '0;
        end else if (t > ONE_U) begin
            return ONE_Q;
        end
        return t[QW-1:0];
    endfunction

    function automatic t_q times3(input t_q a);
        logic [QW+1:0] t;
        t = (QW+2)'(3) * {2'b00, a};
        return t[QW-1:0];
    endfunction

    function automatic t_bern bern(input t_q s, input t_q r, input t_q rr,
                                   input t_q sr, input t_q ss);
        t_bern b;
        b[0] = rnd_q(rr, r);
        b[1] = times3(rnd_q(sr, r));
        b[2] = times3(rnd_q(ss, r));
        b[3] = rnd_q(ss, s);
        return b;
    endfunction

endpackage

/* design/bezier_patch_vertex_deformer.sv */
// Top level of the bicubic Bezier patch vertex deformer.
// Instantiates bpd_param, bpd_patch and bpd_out; depends on bpd_pkg.
`timescale 1ns / 1ps

// The deformer accepts one transaction per clock cycle, loads and vertices alike,
// and presents a vertex result from the last of ten register stages; loads
// return nothing. The ten-stage pipeline (parameter mapping, Bernstein weights,
// patch weights, the 48 displacement products and their adder tree, output gain
// and saturation) moves as one: it advances whenever the output register is
// empty or being taken, so a stalled output holds every stage in place. A load
// takes effect for every vertex accepted after it. The user must write the
// configuration registers through the plain write port only while the pipeline
// is empty; the block itself does not enforce this.
module bezier_patch_vertex_deformer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bpd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bpd_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    bpd_pkg::t_cfg  r_cfg;
    logic           n_en;
    bpd_pkg::t_ctl  n_ctl_in, n_ctl_p, n_ctl_s;
    bpd_pkg::t_in   n_item_p, n_item_s;
    bpd_pkg::t_bern n_bu, n_bv;
    bpd_pkg::t_disp n_disp;

    assign n_en         = !o_out_valid || i_out_ready;
    assign o_in_ready   = n_en;
    assign n_ctl_in.vld = i_in_valid;
    assign n_ctl_in.vtx = (i_in_data.opcode == bpd_pkg::OP_VERTEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x   <= '0;
            r_cfg.center_z   <= '0;
            r_cfg.u_gain     <= bpd_pkg::GAIN_ONE;
            r_cfg.v_gain     <= bpd_pkg::GAIN_ONE;
            r_cfg.out_gain_x <= bpd_pkg::GAIN_ONE;
            r_cfg.out_gain_y <= bpd_pkg::GAIN_ONE;
            r_cfg.out_gain_z <= bpd_pkg::GAIN_ONE;
        end else if (i_cfg_we) begin
            case (bpd_pkg::t_cfg_idx'(i_cfg_index))
                bpd_pkg::CFG_CENTER_X:   r_cfg.center_x   <= i_cfg_data;
                bpd_pkg::CFG_CENTER_Z:   r_cfg.center_z   <= i_cfg_data;
                bpd_pkg::CFG_U_GAIN:     r_cfg.u_gain     <= i_cfg_data;
                bpd_pkg::CFG_V_GAIN:     r_cfg.v_gain     <= i_cfg_data;
                bpd_pkg::CFG_OUT_GAIN_X: r_cfg.out_gain_x <= i_cfg_data;
                bpd_pkg::CFG_OUT_GAIN_Y: r_cfg.out_gain_y <= i_cfg_data;
                bpd_pkg::CFG_OUT_GAIN_Z: r_cfg.out_gain_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bpd_param u_param (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (n_ctl_in),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_ctl   (n_ctl_p),
        .o_item  (n_item_p),
        .o_bu    (n_bu),
        .o_bv    (n_bv)
    );

    bpd_patch u_patch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (n_ctl_p),
        .i_item  (n_item_p),
        .i_bu    (n_bu),
        .i_bv    (n_bv),
        .o_ctl   (n_ctl_s),
        .o_item  (n_item_s),
        .o_disp  (n_disp)
    );

    bpd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (n_ctl_s),
        .i_item  (n_item_s),
        .i_disp  (n_disp),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("pending result dropped during stall");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while pipeline is stalled");

endmodule

/* design/bpd_param.sv */
// Parameter stages: forms u and v from x and z and their cubic Bernstein weights.
// Four register stages; depends on bpd_pkg.
`timescale 1ns / 1ps

module bpd_param (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  bpd_pkg::t_ctl  i_ctl,
    input  bpd_pkg::t_in   i_item,
    input  bpd_pkg::t_cfg  i_cfg,
    output bpd_pkg::t_ctl  o_ctl,
    output bpd_pkg::t_in   o_item,
    output bpd_pkg::t_bern o_bu,
    output bpd_pkg::t_bern o_bv
);

    bpd_pkg::t_ctl r_ctl [4];
    bpd_pkg::t_in  r_item [4];

    logic signed [bpd_pkg::DPW-1:0] r_du, r_dv;
    logic signed [bpd_pkg::UPW-1:0] r_pu, r_pv;
    bpd_pkg::t_q r_su, r_ru, r_rru, r_sru, r_ssu;
    bpd_pkg::t_q r_sv, r_rv, r_rrv, r_srv, r_ssv;
    bpd_pkg::t_bern r_bu, r_bv;

    bpd_pkg::t_q n_su, n_ru, n_sv, n_rv;

    always_comb begin
        n_su = bpd_pkg::param_clamp(r_pu);
        n_ru = bpd_pkg::ONE_Q - n_su;
        n_sv = bpd_pkg::param_clamp(r_pv);
        n_rv = bpd_pkg::ONE_Q - n_sv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < 4; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int k = 1; k < 4; k++) begin
                r_item[k] <= r_item[k-1];
            end
            r_du  <= {i_item.coord_x[bpd_pkg::CW-1], i_item.coord_x}
                   - {i_cfg.center_x[bpd_pkg::CW-1], i_cfg.center_x};
            r_dv  <= {i_item.coord_z[bpd_pkg::CW-1], i_item.coord_z}
                   - {i_cfg.center_z[bpd_pkg::CW-1], i_cfg.center_z};
            r_pu  <= r_du * $signed({1'b0, i_cfg.u_gain});
            r_pv  <= r_dv * $signed({1'b0, i_cfg.v_gain});
            r_su  <= n_su;
            r_ru  <= n_ru;
            r_rru <= bpd_pkg::rnd_q(n_ru, n_ru);
            r_sru <= bpd_pkg::rnd_q(n_su, n_ru);
            r_ssu <= bpd_pkg::rnd_q(n_su, n_su);
            r_sv  <= n_sv;
            r_rv  <= n_rv;
            r_rrv <= bpd_pkg::rnd_q(n_rv, n_rv);
            r_srv <= bpd_pkg::rnd_q(n_sv, n_rv);
            r_ssv <= bpd_pkg::rnd_q(n_sv, n_sv);
            r_bu  <= bpd_pkg::bern(r_su, r_ru, r_rru, r_sru, r_ssu);
            r_bv  <= bpd_pkg::bern(r_sv, r_rv, r_rrv, r_srv, r_ssv);
        end
    end

    assign o_ctl  = r_ctl[3];
    assign o_item = r_item[3];
    assign o_bu   = r_bu;
    assign o_bv   = r_bv;

endmodule

/* design/bpd_patch.sv */
// Patch stages: holds the displacement grid and forms the weighted Bernstein sum.
// Four register stages; depends on bpd_pkg.
`timescale 1ns / 1ps

module bpd_patch (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  bpd_pkg::t_ctl  i_ctl,
    input  bpd_pkg::t_in   i_item,
    input  bpd_pkg::t_bern i_bu,
    input  bpd_pkg::t_bern i_bv,
    output bpd_pkg::t_ctl  o_ctl,
    output bpd_pkg::t_in   o_item,
    output bpd_pkg::t_disp o_disp
);

    bpd_pkg::t_ctl r_ctl [4];
    bpd_pkg::t_in  r_item [4];

    bpd_pkg::t_q r_w [bpd_pkg::NP];
    logic signed [bpd_pkg::CW-1:0]   r_disp [3][bpd_pkg::NP];
    logic signed [bpd_pkg::PPW-1:0]  r_p [3][bpd_pkg::NP];
    logic signed [bpd_pkg::GSW-1:0]  r_g [3][4];
    logic signed [bpd_pkg::DW-1:0]   r_d [3];

    logic signed [bpd_pkg::SUMW-1:0] n_tot [3];
    logic                            n_load;

    // A load writes the grid from the stage where vertices read it, so the
    // order of loads and vertices is kept.
    assign n_load = i_en && r_ctl[0].vld && !r_ctl[0].vtx;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_tot[a] = '0;
            for (int m = 0; m < 4; m++) begin
                n_tot[a] = n_tot[a] + bpd_pkg::SUMW'(r_g[a][m]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_ctl[k] <= '0;
            end
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < bpd_pkg::NP; k++) begin
                    r_disp[a][k] <= '0;
                end
            end
        end else begin
            if (i_en) begin
                r_ctl[0] <= i_ctl;
                for (int k = 1; k < 4; k++) begin
                    r_ctl[k] <= r_ctl[k-1];
                end
            end
            if (n_load) begin
                r_disp[0][r_item[0].point_index] <= r_item[0].coord_x;
                r_disp[1][r_item[0].point_index] <= r_item[0].coord_y;
                r_disp[2][r_item[0].point_index] <= r_item[0].coord_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int k = 1; k < 4; k++) begin
                r_item[k] <= r_item[k-1];
            end
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_w[i*4+j] <= bpd_pkg::rnd_q(i_bu[i], i_bv[j]);
                end
            end
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < bpd_pkg::NP; k++) begin
                    r_p[a][k] <= r_disp[a][k] * $signed({1'b0, r_w[k]});
                end
                for (int m = 0; m < 4; m++) begin
                    r_g[a][m] <= bpd_pkg::GSW'(r_p[a][4*m])   + bpd_pkg::GSW'(r_p[a][4*m+1])
                               + bpd_pkg::GSW'(r_p[a][4*m+2]) + bpd_pkg::GSW'(r_p[a][4*m+3]);
                end
                r_d[a] <= bpd_pkg::DW'(n_tot[a] >>> bpd_pkg::FB);
            end
        end
    end

    assign o_ctl       = r_ctl[3];
    assign o_item      = r_item[3];
    assign o_disp.d_x  = r_d[0];
    assign o_disp.d_y  = r_d[1];
    assign o_disp.d_z  = r_d[2];

endmodule

/* design/bpd_out.sv */
// Output stages: scales the patch displacement per axis, adds it and saturates.
// Two register stages, the second being the output register; depends on bpd_pkg.
`timescale 1ns / 1ps

module bpd_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  bpd_pkg::t_ctl  i_ctl,
    input  bpd_pkg::t_in   i_item,
    input  bpd_pkg::t_disp i_disp,
    input  bpd_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output bpd_pkg::t_out  o_data
);

    localparam logic signed [bpd_pkg::RW-1:0] MAXV = (bpd_pkg::RW'(1) << (bpd_pkg::CW - 1)) - 1;
    localparam logic signed [bpd_pkg::RW-1:0] MINV = -MAXV - 1;

    logic                            r_vld;
    bpd_pkg::t_in                    r_item;
    logic signed [bpd_pkg::GPW-1:0]  r_gp [3];
    logic                            r_out_vld;
    bpd_pkg::t_out                   r_out;

    logic signed [bpd_pkg::RW-1:0]   n_sum [3];
    logic signed [bpd_pkg::CW-1:0]   n_res [3];

    always_comb begin
        n_sum[0] = bpd_pkg::RW'(r_item.coord_x) + bpd_pkg::RW'(r_gp[0] >>> bpd_pkg::FB);
        n_sum[1] = bpd_pkg::RW'(r_item.coord_y) + bpd_pkg::RW'(r_gp[1] >>> bpd_pkg::FB);
        n_sum[2] = bpd_pkg::RW'(r_item.coord_z) + bpd_pkg::RW'(r_gp[2] >>> bpd_pkg::FB);
        for (int a = 0; a < 3; a++) begin
            if (n_sum[a] > MAXV) begin
                n_res[a] = MAXV[bpd_pkg::CW-1:0];
            end else if (n_sum[a] < MINV) begin
                n_res[a] = MINV[bpd_pkg::CW-1:0];
            end else begin
                n_res[a] = n_sum[a][bpd_pkg::CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= i_ctl.vld && i_ctl.vtx;
            r_out_vld <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item      <= i_item;
            r_gp[0]     <= i_disp.d_x * $signed({1'b0, i_cfg.out_gain_x});
            r_gp[1]     <= i_disp.d_y * $signed({1'b0, i_cfg.out_gain_y});
            r_gp[2]     <= i_disp.d_z * $signed({1'b0, i_cfg.out_gain_z});
            r_out.out_x <= n_res[0];
            r_out.out_y <= n_res[1];
            r_out.out_z <= n_res[2];
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule
